### hw/rtl/assert_macros.svh
// Assertion macros shared by the blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons must hold on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cond must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/bbr_pkg.sv
// Shared types and constants of the 3x3 RGB box blur.
package bbr_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_LANES  = 3;
  localparam int WIN_TAPS   = 9;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 12;

  // floor(s / 9) == (s * 3641) >> 15 for every s below 32768.
  localparam logic [SUM_W-1:0] RECIP_NINE  = 12'd3641;
  localparam int               RECIP_SHIFT = 15;

  localparam logic [FW_W-1:0] FW_RESET   = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET   = 13'd480;
  localparam logic [FH_W-1:0] MIN_HEIGHT = 13'd3;
  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam int              MIN_WIDTH  = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam int LANE_RED   = 2;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]       chan_t;
  typedef chan_t [NUM_LANES-1:0]  rgb_t;
  typedef chan_t [WIN_TAPS-1:0]   taps_t;
  typedef taps_t [NUM_LANES-1:0]  lane_taps_t;

  typedef struct packed {
    logic frame_start;
    rgb_t rgb;
  } pix_t;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } tag_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    rgb_t             rgb;
  } result_t;

endpackage

### hw/rtl/bbr_pix_if.sv
// Pixel input channel.
interface bbr_pix_if;
  logic          valid;
  logic          ready;
  logic          frame_start;
  bbr_pkg::chan_t pix_red;
  bbr_pkg::chan_t pix_green;
  bbr_pkg::chan_t pix_blue;

  modport source (output valid, frame_start, pix_red, pix_green, pix_blue, input ready);
  modport sink   (input valid, frame_start, pix_red, pix_green, pix_blue, output ready);
endinterface

### hw/rtl/bbr_res_if.sv
// Filtered pixel result channel.
interface bbr_res_if;
  logic                        valid;
  logic                        ready;
  logic [bbr_pkg::COL_W-1:0]   out_col;
  logic [bbr_pkg::ROW_W-1:0]   out_row;
  bbr_pkg::chan_t              out_red;
  bbr_pkg::chan_t              out_green;
  bbr_pkg::chan_t              out_blue;

  modport source (output valid, out_col, out_row, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_col, out_row, out_red, out_green, out_blue, output ready);
endinterface

### hw/rtl/bbr_cfg_if.sv
// Configuration register write channel.
interface bbr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bbr_pkg::CFG_IDX_W-1:0]    index;
  logic [bbr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/bbr_ram.sv
// Generic simple dual-port RAM with registered read.
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bbr_window.sv
// Position counters, two line stores and the 3x3 window that feeds the lanes.
`include "assert_macros.svh"

module bbr_window #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  bbr_pkg::pix_t               pix,
  input  logic [bbr_pkg::FW_W-1:0]    frame_width,
  input  logic [bbr_pkg::FH_W-1:0]    frame_height,
  output bbr_pkg::tag_t               tag,
  output bbr_pkg::lane_taps_t         taps
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WE_W  = AW + 1;
  localparam int CMP_W = (WE_W > bbr_pkg::FW_W) ? WE_W : bbr_pkg::FW_W;
  localparam int RW    = bbr_pkg::ROW_W;
  localparam int HW    = bbr_pkg::FH_W;
  localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MINW_C = CMP_W'(bbr_pkg::MIN_WIDTH);

  logic [AW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CMP_W-1:0]     fw_ext, width_eff;
  logic [HW-1:0]        height_eff;
  logic [AW-1:0]        col_a, c;
  logic [RW-1:0]        row_a, r;
  logic [HW-1:0]        row_b, r_inc;
  logic [AW:0]          c_inc;
  logic                 col_wrap, end_of_row, end_of_frame, emit;
  logic [AW-1:0]        c_m1;
  logic [AW+bbr_pkg::COL_W-1:0] col_wide;

  logic                 s1_v_r, s1_e_r, fwd_r;
  logic [AW-1:0]        s1_c_r;
  logic [bbr_pkg::COL_W-1:0] s1_col_r;
  logic [RW-1:0]        s1_row_r;
  bbr_pkg::rgb_t        s1_pix_r, fwd_top_r, fwd_mid_r;
  bbr_pkg::rgb_t        top_raw, mid_raw, top_eff, mid_eff;
  bbr_pkg::rgb_t        win_r [6];

  // Effective frame size after clamping.
  always_comb begin
    fw_ext = CMP_W'(frame_width);
    if (fw_ext < MINW_C) begin
      width_eff = MINW_C;
    end else if (fw_ext > MAXW_C) begin
      width_eff = MAXW_C;
    end else begin
      width_eff = fw_ext;
    end
    if (frame_height < bbr_pkg::MIN_HEIGHT) begin
      height_eff = bbr_pkg::MIN_HEIGHT;
    end else if (frame_height > bbr_pkg::MAX_HEIGHT) begin
      height_eff = bbr_pkg::MAX_HEIGHT;
    end else begin
      height_eff = frame_height;
    end
  end

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    col_a    = pix.frame_start ? '0 : col_r;
    row_a    = pix.frame_start ? '0 : row_r;
    col_wrap = CMP_W'(col_a) >= width_eff;
    row_b    = col_wrap ? ({1'b0, row_a} + HW'(1)) : {1'b0, row_a};
    c        = col_wrap ? '0 : col_a;
    r        = (row_b >= height_eff) ? '0 : row_b[RW-1:0];

    c_inc        = {1'b0, c} + WE_W'(1);
    r_inc        = {1'b0, r} + HW'(1);
    end_of_row   = CMP_W'(c_inc) >= width_eff;
    end_of_frame = r_inc >= height_eff;
    col_nxt      = end_of_row ? '0 : c_inc[AW-1:0];
    if (!end_of_row) begin
      row_nxt = r;
    end else if (end_of_frame) begin
      row_nxt = '0;
    end else begin
      row_nxt = r_inc[RW-1:0];
    end

    emit     = (c >= AW'(2)) && (r >= RW'(2));
    c_m1     = c - AW'(1);
    col_wide = {{bbr_pkg::COL_W{1'b0}}, c_m1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s1_e_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r <= acc;
      s1_e_r <= acc && emit;
      fwd_r  <= acc && s1_v_r && (s1_c_r == c);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_c_r   <= c;
      s1_col_r <= col_wide[bbr_pkg::COL_W-1:0];
      s1_row_r <= r - RW'(1);
      s1_pix_r <= pix.rgb;
    end
    fwd_top_r <= mid_eff;
    fwd_mid_r <= s1_pix_r;
  end

  bbr_ram #(
    .WIDTH ($bits(bbr_pkg::rgb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_c_r),
    .wr_data (s1_pix_r),
    .rd_en   (acc),
    .rd_addr (c),
    .rd_data (mid_raw)
  );

  bbr_ram #(
    .WIDTH ($bits(bbr_pkg::rgb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev2 (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_c_r),
    .wr_data (mid_eff),
    .rd_en   (acc),
    .rd_addr (c),
    .rd_data (top_raw)
  );

  // The stores were read while the previous item wrote the same column.
  assign top_eff = fwd_r ? fwd_top_r : top_raw;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_eff;
      win_r[4] <= mid_eff;
      win_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int l = 0; l < bbr_pkg::NUM_LANES; l++) begin
      taps[l] = {win_r[0][l], win_r[1][l], win_r[2][l], win_r[3][l], win_r[4][l],
                 win_r[5][l], top_eff[l], mid_eff[l], s1_pix_r[l]};
    end
  end

  assign tag = '{vld: s1_e_r, col: s1_col_r, row: s1_row_r};

  `ASSERT_IMPLIES(a_fwd_only_col0, clk, rst_n, fwd_r, s1_c_r == '0, "forward off column 0")

endmodule

### hw/rtl/bbr_lane.sv
// One color lane: nine-tap sum, then divide by nine through a reciprocal multiply.
module bbr_lane (
  input  logic           clk,
  input  bbr_pkg::taps_t taps,
  output bbr_pkg::chan_t q
);

  localparam int SW = bbr_pkg::SUM_W;

  logic [SW-1:0]   sum, sum_r;
  logic [2*SW-1:0] prod;
  bbr_pkg::chan_t  q_r;

  always_comb begin
    sum = ((SW'(taps[0]) + SW'(taps[1])) + (SW'(taps[2]) + SW'(taps[3])))
        + ((SW'(taps[4]) + SW'(taps[5])) + (SW'(taps[6]) + SW'(taps[7])))
        + SW'(taps[8]);
    prod = (2*SW)'(sum_r) * (2*SW)'(bbr_pkg::RECIP_NINE);
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
    q_r   <= prod[bbr_pkg::RECIP_SHIFT +: bbr_pkg::PIX_W];
  end

  assign q = q_r;

endmodule

### hw/rtl/bbr_merge.sv
// Joins the lane quotients with their coordinates and buffers result beats.
`include "assert_macros.svh"

module bbr_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  bbr_pkg::tag_t     tag_in,
  input  bbr_pkg::rgb_t     lane_q,
  output logic              room,
  bbr_res_if.source         out_ch
);

  localparam int PW = bbr_pkg::FIFO_PTR_W;
  localparam int CW = bbr_pkg::FIFO_CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(bbr_pkg::FIFO_DEPTH);

  bbr_pkg::tag_t    tag_d1_r, tag_d2_r;
  bbr_pkg::result_t fifo_r [bbr_pkg::FIFO_DEPTH];
  bbr_pkg::result_t head;
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt, occupied;
  logic             push, pop;

  // The tag follows the two register stages of the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_d1_r.vld <= 1'b0;
      tag_d2_r.vld <= 1'b0;
    end else begin
      tag_d1_r.vld <= tag_in.vld;
      tag_d2_r.vld <= tag_d1_r.vld;
    end
    tag_d1_r.col <= tag_in.col;
    tag_d1_r.row <= tag_in.row;
    tag_d2_r.col <= tag_d1_r.col;
    tag_d2_r.row <= tag_d1_r.row;
  end

  assign push = tag_d2_r.vld;
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    occupied = cnt_r + CW'(tag_in.vld) + CW'(tag_d1_r.vld) + CW'(tag_d2_r.vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{col: tag_d2_r.col, row: tag_d2_r.row, rgb: lane_q};
    end
  end

  assign head  = fifo_r[rd_ptr_r];
  assign room  = occupied < DEPTH_C;

  assign out_ch.valid     = cnt_r != '0;
  assign out_ch.out_col   = head.col;
  assign out_ch.out_row   = head.row;
  assign out_ch.out_red   = head.rgb[bbr_pkg::LANE_RED];
  assign out_ch.out_green = head.rgb[bbr_pkg::LANE_GREEN];
  assign out_ch.out_blue  = head.rgb[bbr_pkg::LANE_BLUE];

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && (cnt_r == DEPTH_C), "buffer overflow")
  `ASSERT_IMPLIES(a_credit, clk, rst_n, 1'b1, occupied <= DEPTH_C, "in-flight beats exceed buffer")
  `ASSERT_NEXT(a_pop_count, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - CW'(1), "bad count")

endmodule

### hw/rtl/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur.
//
// Pixels enter on in_ch in raster order, one beat per pixel, with frame_start
// marking the top-left pixel of each frame. For every interior pixel one beat
// leaves on out_ch carrying its column, row and the floor of the per-channel
// mean over its 3x3 neighborhood; border pixels produce no beat.
// The block takes one pixel per clock cycle while the output buffer has room.
// The beat for pixel (c-1, r-1) is produced by the pixel (c, r): the line
// stores are read at the accepting edge, then the sums of the three lane
// adders, the reciprocal multiply and the write into the output buffer are
// registered in that order.
// The frame size is set through cfg_ch (frame_width, frame_height), which is
// always ready; write it only while no pixels are in flight.
// Reset returns the position to the top-left corner, clears the window and
// sets the frame to 640 by 480. The line stores are not cleared; the first two
// rows of each frame write them before any beat depends on them.
// An eight-beat buffer sits in front of out_ch. When the receiver stalls, the
// buffer fills and in_ch.ready drops once the buffered and in-flight results
// reach eight, so no beat is ever dropped.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  bbr_pix_if.sink   in_ch,
  bbr_res_if.source out_ch,
  bbr_cfg_if.sink   cfg_ch
);

  logic [bbr_pkg::FW_W-1:0] frame_width_r, frame_width_nxt;
  logic [bbr_pkg::FH_W-1:0] frame_height_r, frame_height_nxt;
  logic                     acc, room;
  bbr_pkg::pix_t            pix;
  bbr_pkg::tag_t            tag;
  bbr_pkg::lane_taps_t      taps;
  bbr_pkg::rgb_t            lane_q;

  // Configuration registers. Writes to indexes beyond the list are ignored.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bbr_pkg::REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_ch.data[bbr_pkg::FW_W-1:0];
        end
        bbr_pkg::REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_ch.data[bbr_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbr_pkg::FW_RESET;
      frame_height_r <= bbr_pkg::FH_RESET;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // A pixel is taken whenever the output buffer can hold every result that
  // could still be produced by the pixels already in the pipeline.
  assign in_ch.ready = room;
  assign acc         = in_ch.valid && room;
  assign pix         = '{frame_start: in_ch.frame_start,
                         rgb: {in_ch.pix_red, in_ch.pix_green, in_ch.pix_blue}};

  bbr_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .pix          (pix),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .tag          (tag),
    .taps         (taps)
  );

  // One lane per color channel, all working on the same window.
  for (genvar l = 0; l < bbr_pkg::NUM_LANES; l++) begin : g_lane
    bbr_lane u_lane (
      .clk  (clk),
      .taps (taps[l]),
      .q    (lane_q[l])
    );
  end

  bbr_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (tag),
    .lane_q (lane_q),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the 3x3 RGB box blur, driven by directed frames and random streams.
module testbench;

  localparam int MAX_W          = 2048;
  localparam int MAX_H          = 4096;
  localparam int POWERUP_PIXELS = 40;
  localparam int RANDOM_ITEMS   = 870;
  // Spare cycles let pixels that make no beat leave the pipeline.
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  // Cycles in a row with no beat on any channel before the run is declared hung.
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam bbr_pkg::chan_t FULL = 8'd255;
  localparam bbr_pkg::chan_t DARK = 8'd0;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One row of the opening table. When typed is set, the expected mean is the one
  // written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic                      fs;
    bbr_pkg::chan_t            red;
    bbr_pkg::chan_t            green;
    bbr_pkg::chan_t            blue;
    logic                      typed;
    logic [bbr_pkg::COL_W-1:0] col;
    logic [bbr_pkg::ROW_W-1:0] row;
    bbr_pkg::chan_t            m_red;
    bbr_pkg::chan_t            m_green;
    bbr_pkg::chan_t            m_blue;
  } stim_row_t;

  // All rows run with the frame clamped to 3x3, so each frame has one interior pixel
  // at (1, 1) and its beat comes with the ninth pixel.
  stim_row_t opening_rows [29] = '{
    // A bright frame: every channel saturated, so every mean is full scale.
    '{1'b1, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b1, 11'd1, 12'd1, FULL, FULL, FULL},
    // A mixed frame that starts only because the row count wrapped at the height.
    '{1'b0, FULL, 8'hAA, 8'd1, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, 8'h55, 8'd2, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, 8'hAA, 8'd3, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, 8'h55, 8'd4, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, 8'hAA, 8'd5, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, 8'h55, 8'd6, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, 8'hAA, 8'd7, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, 8'h55, 8'd8, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, 8'hAA, 8'd9, 1'b0, '0, '0, DARK, DARK, DARK},
    // Two pixels of a frame, then a frame start mark in the middle of it. The
    // dark frame that follows must ignore the two bright pixels.
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, FULL, FULL, FULL, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b1, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b0, '0, '0, DARK, DARK, DARK},
    '{1'b0, DARK, DARK, DARK, 1'b1, 11'd1, 12'd1, DARK, DARK, DARK}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bbr_pix_if pix_ch ();
  bbr_res_if res_ch ();
  bbr_cfg_if cfg_ch ();

  box_blur_3x3_rgb #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: the two previous rows, the two older window columns and the
  // position of the next pixel, plus the register values as written.
  bbr_pkg::rgb_t             line_above  [MAX_W];
  bbr_pkg::rgb_t             line_above2 [MAX_W];
  bbr_pkg::rgb_t             win_taps    [6];
  int unsigned               next_col;
  int unsigned               next_row;
  logic [bbr_pkg::FW_W-1:0]  reg_width;
  logic [bbr_pkg::FH_W-1:0]  reg_height;

  // Means still owed by the block, oldest first.
  bbr_pkg::result_t pending_means [$];

  int          error_count   = 0;
  int          pixels_sent   = 0;
  int          means_checked = 0;
  int          random_px     = 0;
  int          settings_used = 0;
  int unsigned send_gap_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          quiet_cycles  = 0;

  function automatic void log_error(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("%s", msg);
    end
    error_count++;
  endfunction

  // Out-of-range register values are clamped, not rejected.
  function automatic int unsigned eff_width();
    int unsigned v;
    v = reg_width;
    if (v < bbr_pkg::MIN_WIDTH) return bbr_pkg::MIN_WIDTH;
    if (v > MAX_W) return MAX_W;
    return v;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned v;
    v = reg_height;
    if (v < bbr_pkg::MIN_HEIGHT) return bbr_pkg::MIN_HEIGHT;
    if (v > bbr_pkg::MAX_HEIGHT) return bbr_pkg::MAX_HEIGHT;
    return v;
  endfunction

  // Advances the predictor by one pixel. Returns 1 with the mean of the pixel up
  // and to the left when the new pixel completes an interior window.
  function automatic bit blur_predict(input logic fs, input bbr_pkg::rgb_t px,
                                      output bbr_pkg::result_t mean);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   r;
    int unsigned   sum;
    bbr_pkg::rgb_t top;
    bbr_pkg::rgb_t mid;
    bbr_pkg::rgb_t nine [9];
    bit            got;
    w = eff_width();
    h = eff_height();
    got = 1'b0;
    mean = '0;
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    // Counters left beyond a lowered width or height wrap here.
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;

    top = line_above2[c];
    mid = line_above[c];
    line_above2[c] = mid;
    line_above[c] = px;

    if (c >= 2 && r >= 2) begin
      for (int k = 0; k < 6; k++) nine[k] = win_taps[k];
      nine[6] = top;
      nine[7] = mid;
      nine[8] = px;
      for (int lane = 0; lane < bbr_pkg::NUM_LANES; lane++) begin
        sum = 0;
        for (int k = 0; k < 9; k++) sum += nine[k][lane];
        mean.rgb[lane] = bbr_pkg::chan_t'(sum / 9);
      end
      mean.col = bbr_pkg::COL_W'(c - 1);
      mean.row = bbr_pkg::ROW_W'(r - 1);
      got = 1'b1;
    end

    win_taps[0] = win_taps[3];
    win_taps[1] = win_taps[4];
    win_taps[2] = win_taps[5];
    win_taps[3] = top;
    win_taps[4] = mid;
    win_taps[5] = px;

    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
    return got;
  endfunction

  // Full and empty channels come up often so that saturated and zero sums are common.
  function automatic bbr_pkg::chan_t rand_chan();
    case ($urandom_range(0, 9))
      0: begin
        return DARK;
      end
      1: begin
        return FULL;
      end
      default: begin
        return bbr_pkg::chan_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic bbr_pkg::rgb_t rand_pixel();
    bbr_pkg::rgb_t px;
    px[bbr_pkg::LANE_RED]   = rand_chan();
    px[bbr_pkg::LANE_GREEN] = rand_chan();
    px[bbr_pkg::LANE_BLUE]  = rand_chan();
    return px;
  endfunction

  function automatic void apply_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 65;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        recv_stall_pct = 65;
      end
      default: begin
        send_gap_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endfunction

  // Presents one pixel beat, waits for it to be taken and records the mean it owes.
  // Valid stays high on return so back-to-back beats need only one assignment per edge.
  task automatic send_pixel(input logic fs, input bbr_pkg::rgb_t px, input bit use_typed,
                            input bbr_pkg::result_t typed);
    bbr_pkg::result_t mean;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.frame_start <= fs;
    pix_ch.pix_red     <= px[bbr_pkg::LANE_RED];
    pix_ch.pix_green   <= px[bbr_pkg::LANE_GREEN];
    pix_ch.pix_blue    <= px[bbr_pkg::LANE_BLUE];
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
    if (blur_predict(fs, px, mean)) begin
      pending_means.push_back(use_typed ? typed : mean);
    end
  endtask

  // Holds the input off until every owed mean has left the block.
  task automatic hold_until_drained();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  // Pixels at the frame edges make no beat, so after the last mean arrives the
  // pipeline may still be busy; the extra cycles let it empty.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both frame registers while the block is idle. Reports whether the
  // effective width grew, since the line stores then hold unwritten columns and
  // the next pixel must open a new frame.
  task automatic set_frame(input int unsigned w_val, input int unsigned h_val,
                           output bit widened);
    int unsigned old_w;
    settle();
    old_w = eff_width();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= bbr_pkg::REG_FRAME_WIDTH;
    cfg_ch.data  <= bbr_pkg::CFG_DATA_W'(w_val);
    do @(posedge clk); while (!cfg_ch.ready);
    reg_width = bbr_pkg::FW_W'(w_val);
    cfg_ch.index <= bbr_pkg::REG_FRAME_HEIGHT;
    cfg_ch.data  <= bbr_pkg::CFG_DATA_W'(h_val);
    do @(posedge clk); while (!cfg_ch.ready);
    reg_height = bbr_pkg::FH_W'(h_val);
    cfg_ch.valid <= 1'b0;
    widened = eff_width() > old_w;
    settings_used++;
  endtask

  // Streams random pixels. Frame start marks go on most top-left pixels and are
  // left off the rest, so both explicit and wrapped frames occur. A noisy stream
  // also drops marks into the middle of frames and pauses for the results once
  // halfway and now and then.
  task automatic stream_pixels(input int unsigned count, input bit mark_first,
                               input bit noisy);
    logic fs;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == 0) begin
        fs = mark_first;
      end else if (next_col == 0 && next_row == 0) begin
        fs = ($urandom_range(0, 4) != 0);
      end else begin
        fs = noisy && ($urandom_range(0, 79) == 0);
      end
      if (noisy && (k == count / 2 || $urandom_range(0, 149) == 0)) begin
        hold_until_drained();
      end
      send_pixel(fs, rand_pixel(), 1'b0, '0);
      if (noisy) random_px++;
    end
  endtask

  // Result side: compares each beat with the oldest owed mean and drives a
  // random stall pattern on ready.
  always @(posedge clk) begin : mean_check
    bbr_pkg::result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_means.size() == 0) begin
        log_error($sformatf("unexpected beat: col %0d row %0d rgb %02x %02x %02x",
                            res_ch.out_col, res_ch.out_row, res_ch.out_red,
                            res_ch.out_green, res_ch.out_blue));
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (res_ch.out_col !== want.col || res_ch.out_row !== want.row ||
            res_ch.out_red !== want.rgb[bbr_pkg::LANE_RED] ||
            res_ch.out_green !== want.rgb[bbr_pkg::LANE_GREEN] ||
            res_ch.out_blue !== want.rgb[bbr_pkg::LANE_BLUE]) begin
          log_error($sformatf({"mean mismatch: expected col %0d row %0d rgb %02x %02x %02x,",
                               " got col %0d row %0d rgb %02x %02x %02x"},
                              want.col, want.row, want.rgb[bbr_pkg::LANE_RED],
                              want.rgb[bbr_pkg::LANE_GREEN], want.rgb[bbr_pkg::LANE_BLUE],
                              res_ch.out_col, res_ch.out_row, res_ch.out_red,
                              res_ch.out_green, res_ch.out_blue));
        end
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any beat on any channel proves progress.
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    bit               widened;
    int unsigned      w_val;
    int unsigned      h_val;
    int unsigned      h_lim;
    int unsigned      rows_span;
    int               n_px;
    bbr_pkg::result_t want;
    bbr_pkg::rgb_t    px;

    pix_ch.valid       = 1'b0;
    pix_ch.frame_start = 1'b0;
    pix_ch.pix_red     = '0;
    pix_ch.pix_green   = '0;
    pix_ch.pix_blue    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = bbr_pkg::REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;

    for (int i = 0; i < MAX_W; i++) begin
      line_above[i]  = '0;
      line_above2[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_taps[i] = '0;
    next_col   = 0;
    next_row   = 0;
    reg_width  = bbr_pkg::FW_RESET;
    reg_height = bbr_pkg::FH_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-up check: no register write and no frame start mark. From the reset
    // position these pixels all fall in the top row of a 640-wide frame, so no beat
    // may appear.
    apply_idle(IDLE_RECEIVER);
    stream_pixels(POWERUP_PIXELS, 1'b0, 1'b0);

    // Opening table. Both registers at zero clamp to the smallest 3x3 frame.
    set_frame(0, 0, widened);
    apply_idle(IDLE_NONE);
    foreach (opening_rows[i]) begin
      px[bbr_pkg::LANE_RED]   = opening_rows[i].red;
      px[bbr_pkg::LANE_GREEN] = opening_rows[i].green;
      px[bbr_pkg::LANE_BLUE]  = opening_rows[i].blue;
      want.col                     = opening_rows[i].col;
      want.row                     = opening_rows[i].row;
      want.rgb[bbr_pkg::LANE_RED]   = opening_rows[i].m_red;
      want.rgb[bbr_pkg::LANE_GREEN] = opening_rows[i].m_green;
      want.rgb[bbr_pkg::LANE_BLUE]  = opening_rows[i].m_blue;
      send_pixel(opening_rows[i].fs, px, opening_rows[i].typed, want);
    end

    // Random part: small frames, each setting under the next idle pattern. A
    // narrower frame may carry on without a mark, which makes the counters wrap
    // against the new size; a wider one must start a fresh frame. The last
    // setting is cut short so the random pixel count comes out exact.
    while (random_px < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          w_val = $urandom_range(0, 2);
        end
        1: begin
          w_val = $urandom_range(17, 48);
        end
        default: begin
          w_val = $urandom_range(3, 16);
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          h_val = $urandom_range(0, 2);
        end
        1: begin
          h_val = $urandom_range(MAX_H + 1, 8191);
        end
        default: begin
          h_val = $urandom_range(3, 8);
        end
      endcase
      set_frame(w_val, h_val, widened);
      apply_idle(idle_mode_t'(settings_used % 4));
      h_lim = (eff_height() > 8) ? 8 : eff_height();
      rows_span = $urandom_range(3, h_lim + 4);
      n_px = int'(eff_width() * rows_span + $urandom_range(0, eff_width() - 1));
      if (n_px > RANDOM_ITEMS - random_px) n_px = RANDOM_ITEMS - random_px;
      stream_pixels(n_px, widened || ($urandom_range(0, 1) == 1), 1'b1);
    end

    // Size clamps: an oversized width clamps to 2048 columns, so a short burst
    // stays in the top row and makes no beat; an oversized height clamps to
    // 4096 rows, so a narrow frame runs well past 8 rows without wrapping.
    set_frame(4095, 3, widened);
    apply_idle(idle_mode_t'(settings_used % 4));
    stream_pixels(40, 1'b1, 1'b0);
    set_frame(0, 8191, widened);
    apply_idle(idle_mode_t'(settings_used % 4));
    stream_pixels(3 * 24, 1'b1, 1'b0);

    // Wind down: every owed mean must arrive, and nothing may follow it.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels over %0d frame settings and compared %0d means.",
             pixels_sent, settings_used, means_checked);
    $display("Frames ran from the clamped 3x3 minimum to sizes clamped at 2048 by 4096.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_pix_if.sv
hw/rtl/bbr_res_if.sv
hw/rtl/bbr_cfg_if.sv
hw/rtl/bbr_ram.sv
hw/rtl/bbr_window.sv
hw/rtl/bbr_lane.sv
hw/rtl/bbr_merge.sv
hw/rtl/box_blur_3x3_rgb.sv
test/testbench.sv
